### sv/imst_pkg.sv
package imst_pkg;

   // Sizes of the stored graph.
   localparam int MAX_NODES = 256;
   localparam int WEIGHT_BITS = 16;
   localparam int NODE_BITS = 9;
   localparam int IDX_BITS = $clog2(MAX_NODES);
   localparam int CNT_BITS = $clog2(MAX_NODES + 1);
   localparam int RANK_BITS = 4;
   localparam int SUM_BITS = 24;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register index taken from paddr bit 2.
   localparam logic REG_NODE_COUNT = 1'b0;

   // Field order gives the sort order: weight, then from_node, then to_node.
   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic [NODE_BITS-1:0]   from_node;
      logic [NODE_BITS-1:0]   to_node;
   } edge_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  parent;
      logic [RANK_BITS-1:0] rank;
   } set_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] tree_weight;
      logic                spanning;
      logic                bad_edge;
   } result_type;

   // Request from the front end to the sequencer.
   typedef struct packed {
      logic                 start;
      edge_type             edge_in;
      logic                 bad;
      logic [CNT_BITS-1:0]  nodes;
   } job_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN_RD,
      ST_SCAN_EX,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INS_WR,
      ST_KR_RD,
      ST_KR_EX,
      ST_FIND_RD,
      ST_FIND_EX,
      ST_UNION_A,
      ST_UNION_B,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_SPAN,
      ST_SP_NEXT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      FP_A,
      FP_B,
      FP_ROOT,
      FP_NODE
   } find_phase_type;

   // Node numbers 1..MAX_NODES map to memory rows 0..MAX_NODES-1.
   function automatic logic [IDX_BITS-1:0] node_idx(input logic [NODE_BITS-1:0] n);
      logic [NODE_BITS-1:0] d;
      d = n - NODE_BITS'(1);
      return d[IDX_BITS-1:0];
   endfunction

endpackage

### sv/imst_req_if.sv
interface imst_req_if;
   logic                         valid;
   logic                         ready;
   logic [imst_pkg::NODE_BITS-1:0]   from_node;
   logic [imst_pkg::NODE_BITS-1:0]   to_node;
   logic [imst_pkg::WEIGHT_BITS-1:0] edge_weight;

   modport source (output valid, from_node, to_node, edge_weight, input ready);
   modport sink (input valid, from_node, to_node, edge_weight, output ready);
endinterface

### sv/imst_rsp_if.sv
interface imst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [imst_pkg::SUM_BITS-1:0] tree_weight;
   logic                          spanning;
   logic                          bad_edge;

   modport source (output valid, tree_weight, spanning, bad_edge, input ready);
   modport sink (input valid, tree_weight, spanning, bad_edge, output ready);
endinterface

### sv/incremental_minimum_spanning_tree_top.sv
// Incremental minimum spanning forest over a stream of weighted edges.
// The req channel carries one edge per beat (from_node, to_node, edge_weight).
// The rsp channel returns one beat per edge: tree_weight, spanning, bad_edge.
// node_count is written over the csr APB port at byte address 0 and can be
// read back; write it only while no edge is in flight.
// Each edge first resets all 256 rows of the union-find memory; an edge in
// range then walks the stored edges in sorted order to find its slot, moves
// entries up and is inserted, unless it is already stored or the list is
// full. Each stored edge then gets two root searches (union by rank keeps a
// search within 9 nodes, that is 8 hops) and, if the roots differ, a union.
// Removing the cycle edge moves entries down, and the connectivity sweep
// runs a root search per node until a node with another root is found.
// The single read port of the edge and set memories paces every loop.
// One edge is worked on at a time; req.ready is high only while idle.
// A finished result waits in the rsp output register while the next edge
// is taken; if the register is still full when that edge is done, the
// block holds the new result until rsp.ready frees the register.
// Reset empties the edge list, sets node_count to 1 and clears both channels.
module incremental_minimum_spanning_tree_top (
   input  logic                                clock,
   input  logic                                reset,
   imst_req_if.sink                            req,
   imst_rsp_if.source                          rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [imst_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [imst_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [imst_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import imst_pkg::*;

   logic [NODE_BITS-1:0] node_count_ff, node_count_in;
   logic [CNT_BITS-1:0]  nodes;
   logic                 bad;
   logic                 idle;
   job_type              job;
   result_type           result;

   // Register write on the access phase.
   always_comb begin
      node_count_in = node_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_NODE_COUNT) begin
         node_count_in = csr_pwdata[NODE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_BITS'(1);
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_NODE_COUNT) ?
                       CSR_DATA_BITS'(node_count_ff) : '0;

   // Effective node count and endpoint range check.
   always_comb begin
      if (node_count_ff == '0) begin
         nodes = CNT_BITS'(1);
      end else if (CNT_BITS'(node_count_ff) > CNT_BITS'(MAX_NODES)) begin
         nodes = CNT_BITS'(MAX_NODES);
      end else begin
         nodes = CNT_BITS'(node_count_ff);
      end
      bad = (req.from_node == '0) || (CNT_BITS'(req.from_node) > nodes) ||
            (req.to_node == '0) || (CNT_BITS'(req.to_node) > nodes);
   end

   assign req.ready = idle;
   assign job = '{start: req.valid && idle,
                  edge_in: '{weight: req.edge_weight, from_node: req.from_node,
                             to_node: req.to_node},
                  bad: bad,
                  nodes: nodes};

   imst_core u_core (
      .clock(clock),
      .reset(reset),
      .job(job),
      .idle(idle),
      .result(result),
      .result_valid(rsp.valid),
      .result_ready(rsp.ready)
   );

   assign rsp.tree_weight = result.tree_weight;
   assign rsp.spanning = result.spanning;
   assign rsp.bad_edge = result.bad_edge;

endmodule

### sv/imst_ram.sv
module imst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### sv/imst_core.sv
module imst_core (
   input  logic                 clock,
   input  logic                 reset,
   input  imst_pkg::job_type    job,
   output logic                 idle,
   output imst_pkg::result_type result,
   output logic                 result_valid,
   input  logic                 result_ready
);
   import imst_pkg::*;

   state_type            state_ff, state_in;
   find_phase_type       ph_ff, ph_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   logic [CNT_BITS-1:0]  len_ff, len_in;
   logic [CNT_BITS-1:0]  cyc_at_ff, cyc_at_in;
   logic                 have_cyc_ff, have_cyc_in;
   edge_type             new_ff, new_in;
   edge_type             cur_ff, cur_in;
   logic                 bad_ff, bad_in;
   logic [CNT_BITS-1:0]  n_ff, n_in;
   logic [IDX_BITS-1:0]  find_ff, find_in;
   logic [IDX_BITS-1:0]  ra_ff, ra_in, rb_ff, rb_in;
   logic [RANK_BITS-1:0] rka_ff, rka_in, rkb_ff, rkb_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic                 span_ff, span_in;
   result_type           out_ff, out_in;
   logic                 out_v_ff, out_v_in;

   logic                 e_we;
   logic [IDX_BITS-1:0]  e_waddr, e_raddr;
   edge_type             e_wdata, e_rdata;
   logic                 s_we;
   logic [IDX_BITS-1:0]  s_waddr, s_raddr;
   set_type              s_wdata, s_rdata;
   logic                 out_free;
   logic [SUM_BITS:0]    sum_ext;
   logic [CNT_BITS-1:0]  idx_m1, idx_p1;

   // Sorted edge list.
   imst_ram #(.WIDTH($bits(edge_type)), .DEPTH(MAX_NODES)) u_edge_ram (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata)
   );

   // Union-find parent and rank per node.
   imst_ram #(.WIDTH($bits(set_type)), .DEPTH(MAX_NODES)) u_set_ram (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata)
   );

   assign out_free = !out_v_ff || result_ready;
   assign idx_m1 = idx_ff - CNT_BITS'(1);
   assign idx_p1 = idx_ff + CNT_BITS'(1);
   assign sum_ext = {1'b0, sum_ff} + (SUM_BITS + 1)'(cur_ff.weight);
   assign idle = (state_ff == ST_IDLE);
   assign result = out_ff;
   assign result_valid = out_v_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (job.start) state_in = ST_INIT;
         ST_INIT: begin
            if (idx_ff == CNT_BITS'(MAX_NODES - 1)) begin
               state_in = bad_ff ? ST_KR_RD : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD:  state_in = (idx_ff == len_ff) ? ST_SHIFT_RD : ST_SCAN_EX;
         ST_SCAN_EX: begin
            if (new_ff == e_rdata) begin
               state_in = ST_KR_RD;
            end else if (new_ff < e_rdata) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (len_ff == CNT_BITS'(MAX_NODES)) begin
               state_in = ST_KR_RD;
            end else if (idx_ff == pos_ff) begin
               state_in = ST_INS_WR;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_INS_WR:   state_in = ST_KR_RD;
         ST_KR_RD: begin
            if (idx_ff == len_ff) begin
               state_in = have_cyc_ff ? ST_DEL_RD : ST_SPAN;
            end else begin
               state_in = ST_KR_EX;
            end
         end
         ST_KR_EX:    state_in = ST_FIND_RD;
         ST_FIND_RD:  state_in = ST_FIND_EX;
         ST_FIND_EX: begin
            if (s_rdata.parent != find_ff) begin
               state_in = ST_FIND_RD;
            end else begin
               unique case (ph_ff)
                  FP_A:    state_in = ST_FIND_RD;
                  FP_B:    state_in = (ra_ff == find_ff) ? ST_KR_RD : ST_UNION_A;
                  FP_ROOT: state_in = ST_SP_NEXT;
                  FP_NODE: state_in = (find_ff == ra_ff) ? ST_SP_NEXT : ST_DONE;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_UNION_A:  state_in = (rka_ff == rkb_ff) ? ST_UNION_B : ST_KR_RD;
         ST_UNION_B:  state_in = ST_KR_RD;
         ST_DEL_RD:   state_in = (idx_p1 >= len_ff) ? ST_SPAN : ST_DEL_WR;
         ST_DEL_WR:   state_in = ST_DEL_RD;
         ST_SPAN:     state_in = ST_FIND_RD;
         ST_SP_NEXT:  state_in = (idx_ff >= n_ff) ? ST_DONE : ST_FIND_RD;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory ports and result register.
   always_comb begin
      ph_in = ph_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      cyc_at_in = cyc_at_ff;
      have_cyc_in = have_cyc_ff;
      new_in = new_ff;
      cur_in = cur_ff;
      bad_in = bad_ff;
      n_in = n_ff;
      find_in = find_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      rka_in = rka_ff;
      rkb_in = rkb_ff;
      sum_in = sum_ff;
      span_in = span_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && !result_ready;
      e_we = 1'b0;
      e_waddr = idx_ff[IDX_BITS-1:0];
      e_wdata = e_rdata;
      e_raddr = idx_ff[IDX_BITS-1:0];
      s_we = 1'b0;
      s_waddr = idx_ff[IDX_BITS-1:0];
      s_wdata = '{parent: idx_ff[IDX_BITS-1:0], rank: '0};
      s_raddr = find_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job.start) begin
               new_in = job.edge_in;
               bad_in = job.bad;
               n_in = job.nodes;
               idx_in = '0;
            end
         end
         // Every node starts as its own root.
         ST_INIT: begin
            s_we = 1'b1;
            idx_in = idx_p1;
            have_cyc_in = 1'b0;
            sum_in = '0;
            span_in = 1'b1;
            if (idx_ff == CNT_BITS'(MAX_NODES - 1)) begin
               idx_in = '0;
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == len_ff) begin
               pos_in = idx_ff;
               idx_in = len_ff;
            end
         end
         // Find the first stored edge that sorts after the new one.
         ST_SCAN_EX: begin
            if (new_ff == e_rdata) begin
               idx_in = '0;
            end else if (new_ff < e_rdata) begin
               pos_in = idx_ff;
               idx_in = len_ff;
            end else begin
               idx_in = idx_p1;
            end
         end
         ST_SHIFT_RD: begin
            e_raddr = idx_m1[IDX_BITS-1:0];
            if (len_ff == CNT_BITS'(MAX_NODES)) begin
               idx_in = '0;
            end
         end
         // Move one entry up to open the slot.
         ST_SHIFT_WR: begin
            e_we = 1'b1;
            e_wdata = e_rdata;
            idx_in = idx_m1;
         end
         ST_INS_WR: begin
            e_we = 1'b1;
            e_waddr = pos_ff[IDX_BITS-1:0];
            e_wdata = new_ff;
            len_in = len_ff + CNT_BITS'(1);
            idx_in = '0;
         end
         ST_KR_RD: begin
            if (idx_ff == len_ff) begin
               idx_in = cyc_at_ff;
            end
         end
         ST_KR_EX: begin
            cur_in = e_rdata;
            find_in = node_idx(e_rdata.from_node);
            ph_in = FP_A;
         end
         // One hop toward the root per visit.
         ST_FIND_EX: begin
            if (s_rdata.parent != find_ff) begin
               find_in = s_rdata.parent;
            end else begin
               unique case (ph_ff)
                  FP_A: begin
                     ra_in = find_ff;
                     rka_in = s_rdata.rank;
                     find_in = node_idx(cur_ff.to_node);
                     ph_in = FP_B;
                  end
                  FP_B: begin
                     rb_in = find_ff;
                     rkb_in = s_rdata.rank;
                     if (ra_ff == find_ff) begin
                        have_cyc_in = 1'b1;
                        cyc_at_in = idx_ff;
                        idx_in = idx_p1;
                     end else begin
                        sum_in = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
                     end
                  end
                  FP_ROOT: begin
                     ra_in = find_ff;
                     idx_in = CNT_BITS'(1);
                  end
                  FP_NODE: begin
                     if (find_ff != ra_ff) begin
                        span_in = 1'b0;
                     end
                  end
                  default: span_in = 1'b0;
               endcase
            end
         end
         // Link the lower-ranked root under the other one.
         ST_UNION_A: begin
            s_we = 1'b1;
            if (rka_ff < rkb_ff) begin
               s_waddr = ra_ff;
               s_wdata = '{parent: rb_ff, rank: rka_ff};
            end else begin
               s_waddr = rb_ff;
               s_wdata = '{parent: ra_ff, rank: rkb_ff};
            end
            if (rka_ff != rkb_ff) begin
               idx_in = idx_p1;
            end
         end
         ST_UNION_B: begin
            s_we = 1'b1;
            s_waddr = ra_ff;
            s_wdata = '{parent: ra_ff,
                        rank: (rka_ff == '1) ? rka_ff : rka_ff + RANK_BITS'(1)};
            idx_in = idx_p1;
         end
         // Close the gap left by the removed cycle edge.
         ST_DEL_RD: begin
            e_raddr = idx_p1[IDX_BITS-1:0];
            if (idx_p1 >= len_ff) begin
               len_in = len_ff - CNT_BITS'(1);
            end
         end
         ST_DEL_WR: begin
            e_we = 1'b1;
            e_wdata = e_rdata;
            idx_in = idx_p1;
         end
         ST_SPAN: begin
            find_in = '0;
            ph_in = FP_ROOT;
         end
         ST_SP_NEXT: begin
            find_in = idx_ff[IDX_BITS-1:0];
            ph_in = FP_NODE;
            idx_in = idx_p1;
         end
         ST_DONE: begin
            if (out_free) begin
               out_in = '{tree_weight: sum_ff, spanning: span_ff, bad_edge: bad_ff};
               out_v_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         out_v_ff <= out_v_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      ph_ff <= ph_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      cyc_at_ff <= cyc_at_in;
      have_cyc_ff <= have_cyc_in;
      new_ff <= new_in;
      cur_ff <= cur_in;
      bad_ff <= bad_in;
      n_ff <= n_in;
      find_ff <= find_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      rka_ff <= rka_in;
      rkb_ff <= rkb_in;
      sum_ff <= sum_in;
      span_ff <= span_in;
      out_ff <= out_in;
   end

endmodule
